// ----- hw/rtl/xsb_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, field widths, command and result codes for the XOR sprite blitter.
// No dependencies; used by the channel interfaces and the top level.
package xsb_pkg;

	localparam int CMD_W = 2;
	localparam int X_W = 9;
	localparam int Y_W = 8;
	localparam int WB_W = 5;
	localparam int HR_W = 7;
	localparam int BYTE_W = 8;
	localparam int COLOR_W = 2;
	localparam int RADDR_W = 15;
	localparam int KIND_W = 2;

	localparam logic [CMD_W-1:0] CMD_START = 2'd0;
	localparam logic [CMD_W-1:0] CMD_DATA = 2'd1;
	localparam logic [CMD_W-1:0] CMD_PLOT = 2'd2;
	localparam logic [CMD_W-1:0] CMD_READ = 2'd3;

	localparam logic [KIND_W-1:0] KIND_DONE = 2'd0;
	localparam logic [KIND_W-1:0] KIND_PIXEL = 2'd1;
	localparam logic [KIND_W-1:0] KIND_READ = 2'd2;

	localparam logic [BYTE_W-1:0] PIX_TOP_MASK = 8'hC0;
	localparam logic [BYTE_W-1:0] PIX_LOW_BITS = 8'h55;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic [X_W-1:0] x_pos;
		logic [Y_W-1:0] y_pos;
		logic [WB_W-1:0] width_bytes;
		logic [HR_W-1:0] height_rows;
		logic [BYTE_W-1:0] data_byte;
		logic [COLOR_W-1:0] pixel_color;
		logic xor_mode;
		logic [RADDR_W-1:0] read_address;
	} req_t;

	typedef struct packed {
		logic [KIND_W-1:0] result_kind;
		logic collided;
		logic [BYTE_W-1:0] out_value;
	} rsp_t;

	// widen every nonzero 2-bit pixel to 11b
	function automatic logic [BYTE_W-1:0] fill_mask(input logic [BYTE_W-1:0] v);
		logic [BYTE_W-1:0] m;
		m = (v | (v >> 1)) & PIX_LOW_BITS;
		return m | (m << 1);
	endfunction

endpackage

// ----- hw/rtl/xsb_req_if.sv -----
`timescale 1ns / 1ps
// Command channel: valid/ready handshake carrying one req_t transaction.
// Depends on xsb_pkg.
interface xsb_req_if import xsb_pkg::*; ();
	logic valid;
	logic ready;
	req_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ----- hw/rtl/xsb_rsp_if.sv -----
`timescale 1ns / 1ps
// Result channel: valid/ready handshake carrying one rsp_t transaction.
// Depends on xsb_pkg.
interface xsb_rsp_if import xsb_pkg::*; ();
	logic valid;
	logic ready;
	rsp_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ----- hw/rtl/xor_sprite_blitter_collision.sv -----
`timescale 1ns / 1ps
// XOR sprite blitter over a line-doubled 2bpp frame memory, with pixel plot and byte read.
// Depends on xsb_pkg, xsb_req_if, xsb_rsp_if.
//
//   channel | dir | payload | transfer
//   req     | in  | req_t   | valid & ready
//   rsp     | out | rsp_t   | valid & ready, one registered slot
//
// Steps: a drawn sprite byte reads, then writes both row copies (ST_W1, ST_W2); a clipped byte writes nothing;
// a row-end spill adds ST_SPILL, W1, W2, the last byte ST_SEND; plot W1, W2, SEND; read RDATA, SEND.
// Each drawn byte costs one read and two writes on the single write port of the frame memory.
// After reset a clearing pass writes zero to all SCREEN_ROWS*2*LINE_BYTES bytes of the frame memory
// (32000 by default), with req.ready low.
// A held result stalls the next result in its send step, with req.ready low; commands before it are taken meanwhile.
module xor_sprite_blitter_collision import xsb_pkg::*; #(
	parameter int SCREEN_ROWS = 200,
	parameter int LINE_BYTES = 80,
	parameter int MAX_SPRITE_BYTES = 16,
	parameter int MAX_SPRITE_ROWS = 64
) (
	input logic clk,
	input logic arst_n,
	xsb_req_if.sink req,
	xsb_rsp_if.source rsp
);

	localparam int PAIR_BYTES = 2 * LINE_BYTES;
	localparam int STORE_SIZE = SCREEN_ROWS * PAIR_BYTES;
	localparam int ADDR_W = $clog2(STORE_SIZE);
	localparam int AVAIL_W = $clog2(LINE_BYTES + 1);
	localparam int COL_W = X_W - 2;
	localparam logic [ADDR_W-1:0] PAIR_STEP = ADDR_W'(PAIR_BYTES);
	localparam logic [ADDR_W-1:0] COPY_OFS = ADDR_W'(LINE_BYTES);
	localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(STORE_SIZE - 1);
	localparam logic [Y_W-1:0] ROW_TOP = Y_W'(SCREEN_ROWS - 1);

	localparam logic [2:0] ST_CLR = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_W1 = 3'd2;
	localparam logic [2:0] ST_W2 = 3'd3;
	localparam logic [2:0] ST_SPILL = 3'd4;
	localparam logic [2:0] ST_RDATA = 3'd5;
	localparam logic [2:0] ST_SEND = 3'd6;

	logic [BYTE_W-1:0] mem [STORE_SIZE];
	logic [BYTE_W-1:0] rd_data;
	logic rd_en, wr_en;
	logic [ADDR_W-1:0] rd_addr, wr_addr;
	logic [BYTE_W-1:0] wr_data;

	logic [2:0] state_q, state_d;
	logic [ADDR_W-1:0] clr_q;

	logic [ADDR_W-1:0] row_base_q;
	logic [WB_W-1:0] byte_in_row_q, clip_w_q, sprite_w_q;
	logic [HR_W-1:0] rows_left_q, rows_lim_q;
	logic [1:0] shift_q;
	logic [BYTE_W-1:0] carry_q;
	logic spill_on_q, hit_q, active_q;

	logic [ADDR_W-1:0] op_addr_q, spill_addr_q;
	logic [BYTE_W-1:0] op_val_q, op_mask_q, spill_val_q, wb_q;
	logic [1:0] op_pix_q;
	logic op_plot_q, op_xor_q, spill_pend_q, fin_pend_q;
	logic [KIND_W-1:0] res_kind_q, out_kind_q;
	logic [BYTE_W-1:0] res_val_q, out_val_q;
	logic out_valid_q, out_coll_q;

	req_t p;
	logic acc, out_free;
	logic [COL_W-1:0] col;
	logic col_in, y_in, plot_ok, rd_in_rng, empty;
	logic [WB_W-1:0] w_sat, clip_w;
	logic [HR_W-1:0] h_sat, lim, left_dec, lim_dec;
	logic [AVAIL_W-1:0] avail;
	logic [Y_W:0] y_inc;
	logic [Y_W-1:0] row_idx;
	logic [ADDR_W-1:0] pos_addr, cell_addr, spill_addr;
	logic [2*BYTE_W-1:0] shifted;
	logic [BYTE_W-1:0] cell_val, carry_nx;
	logic draw, do_cell, row_end, do_spill, finish;
	logic [WB_W:0] bir_inc;
	logic [1:0] pix;
	logic [BYTE_W-1:0] pmask, pcolor, old_sh, new_byte;
	logic cell_hit;

	assign req.ready = (state_q == ST_IDLE);
	assign rsp.valid = out_valid_q;
	assign rsp.payload.result_kind = out_kind_q;
	assign rsp.payload.collided = out_coll_q;
	assign rsp.payload.out_value = out_val_q;

	always_comb begin
		p = req.payload;
		acc = req.valid && req.ready;
		out_free = !out_valid_q || rsp.ready;
		col = p.x_pos[X_W-1:2];
		col_in = int'(col) < LINE_BYTES;
		y_in = int'(p.y_pos) < SCREEN_ROWS;
		plot_ok = col_in && y_in;
		rd_in_rng = int'(p.read_address) < STORE_SIZE;

		w_sat = (int'(p.width_bytes) > MAX_SPRITE_BYTES) ? WB_W'(MAX_SPRITE_BYTES) : p.width_bytes;
		h_sat = (int'(p.height_rows) > MAX_SPRITE_ROWS) ? HR_W'(MAX_SPRITE_ROWS) : p.height_rows;
		empty = (w_sat == '0) || (h_sat == '0);
		avail = col_in ? AVAIL_W'(LINE_BYTES - int'(col)) : '0;
		clip_w = (int'(w_sat) < int'(avail)) ? w_sat : WB_W'(avail);
		y_inc = {1'b0, p.y_pos} + 1'b1;
		lim = (int'(h_sat) < int'(y_inc)) ? h_sat : HR_W'(y_inc);
		row_idx = ROW_TOP - p.y_pos;
		pos_addr = ADDR_W'(row_idx) * PAIR_STEP + ADDR_W'(col);

		shifted = {p.data_byte, BYTE_W'(0)} >> {shift_q, 1'b0};
		cell_val = shifted[2*BYTE_W-1:BYTE_W] | carry_q;
		carry_nx = shifted[BYTE_W-1:0];
		draw = rows_lim_q != '0;
		do_cell = draw && (byte_in_row_q < clip_w_q);
		bir_inc = {1'b0, byte_in_row_q} + 1'b1;
		row_end = bir_inc >= {1'b0, sprite_w_q};
		do_spill = row_end && draw && spill_on_q;
		left_dec = (rows_left_q != '0) ? rows_left_q - 1'b1 : rows_left_q;
		lim_dec = draw ? rows_lim_q - 1'b1 : rows_lim_q;
		finish = row_end && (left_dec == '0);
		cell_addr = row_base_q + ADDR_W'(byte_in_row_q);
		spill_addr = row_base_q + ADDR_W'(sprite_w_q);

		pix = p.x_pos[1:0];
		pmask = PIX_TOP_MASK >> {pix, 1'b0};
		pcolor = {p.pixel_color, (BYTE_W-COLOR_W)'(0)} >> {pix, 1'b0};

		old_sh = rd_data << {op_pix_q, 1'b0};
		if (op_plot_q && !op_xor_q) begin
			new_byte = (rd_data & ~op_mask_q) | op_val_q;
		end else begin
			new_byte = rd_data ^ op_val_q;
		end
		cell_hit = (rd_data & fill_mask(op_val_q)) != '0;
	end

	always_comb begin
		state_d = state_q;
		rd_en = 1'b0;
		rd_addr = cell_addr;
		wr_en = 1'b0;
		wr_addr = op_addr_q;
		wr_data = new_byte;
		case (state_q)
			ST_CLR: begin
				wr_en = 1'b1;
				wr_addr = clr_q;
				wr_data = '0;
				if (clr_q == CLR_LAST) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (acc) begin
					case (p.cmd)
						CMD_START: begin
							if (empty) state_d = ST_SEND;
						end
						CMD_DATA: begin
							if (active_q) begin
								if (do_cell) begin
									rd_en = 1'b1;
									rd_addr = cell_addr;
									state_d = ST_W1;
								end else if (do_spill) begin
									state_d = ST_SPILL;
								end else if (finish) begin
									state_d = ST_SEND;
								end
							end
						end
						CMD_PLOT: begin
							if (plot_ok) begin
								rd_en = 1'b1;
								rd_addr = pos_addr;
								state_d = ST_W1;
							end else begin
								state_d = ST_SEND;
							end
						end
						CMD_READ: begin
							if (rd_in_rng) begin
								rd_en = 1'b1;
								rd_addr = ADDR_W'(p.read_address);
								state_d = ST_RDATA;
							end else begin
								state_d = ST_SEND;
							end
						end
						default: state_d = state_q;
					endcase
				end
			end
			ST_W1: begin
				wr_en = 1'b1;
				state_d = ST_W2;
			end
			ST_W2: begin
				wr_en = 1'b1;
				wr_addr = op_addr_q + COPY_OFS;
				wr_data = wb_q;
				if (op_plot_q) state_d = ST_SEND;
				else if (spill_pend_q) state_d = ST_SPILL;
				else if (fin_pend_q) state_d = ST_SEND;
				else state_d = ST_IDLE;
			end
			ST_SPILL: begin
				rd_en = 1'b1;
				rd_addr = spill_addr_q;
				state_d = ST_W1;
			end
			ST_RDATA: state_d = ST_SEND;
			ST_SEND: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (rd_en) rd_data <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			clr_q <= '0;
			row_base_q <= '0;
			byte_in_row_q <= '0;
			rows_left_q <= '0;
			rows_lim_q <= '0;
			clip_w_q <= '0;
			sprite_w_q <= '0;
			shift_q <= '0;
			carry_q <= '0;
			spill_on_q <= 1'b0;
			hit_q <= 1'b0;
			active_q <= 1'b0;
			op_plot_q <= 1'b0;
			spill_pend_q <= 1'b0;
			fin_pend_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLR) clr_q <= clr_q + 1'b1;
			if (state_q == ST_SEND && out_free) out_valid_q <= 1'b1;
			else if (rsp.ready) out_valid_q <= 1'b0;
			if (state_q == ST_W1 && !op_plot_q && cell_hit) hit_q <= 1'b1;
			if (state_q == ST_SPILL) spill_pend_q <= 1'b0;
			if (acc) begin
				case (p.cmd)
					CMD_START: begin
						hit_q <= 1'b0;
						if (empty) begin
							active_q <= 1'b0;
						end else begin
							sprite_w_q <= w_sat;
							clip_w_q <= clip_w;
							spill_on_q <= int'(w_sat) < int'(avail);
							shift_q <= p.x_pos[1:0];
							rows_lim_q <= y_in ? lim : '0;
							row_base_q <= y_in ? pos_addr : '0;
							byte_in_row_q <= '0;
							rows_left_q <= h_sat;
							carry_q <= '0;
							active_q <= 1'b1;
						end
					end
					CMD_DATA: begin
						if (active_q) begin
							op_plot_q <= 1'b0;
							spill_pend_q <= do_spill;
							fin_pend_q <= finish;
							if (row_end) begin
								carry_q <= '0;
								byte_in_row_q <= '0;
								row_base_q <= row_base_q + PAIR_STEP;
								rows_lim_q <= lim_dec;
								rows_left_q <= left_dec;
								if (left_dec == '0) active_q <= 1'b0;
							end else begin
								carry_q <= carry_nx;
								byte_in_row_q <= bir_inc[WB_W-1:0];
							end
						end
					end
					CMD_PLOT: begin
						op_plot_q <= 1'b1;
						spill_pend_q <= 1'b0;
						fin_pend_q <= 1'b0;
					end
					default: fin_pend_q <= 1'b0;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			case (p.cmd)
				CMD_START: begin
					res_kind_q <= KIND_DONE;
					res_val_q <= '0;
				end
				CMD_DATA: begin
					op_addr_q <= cell_addr;
					op_val_q <= cell_val;
					spill_addr_q <= spill_addr;
					spill_val_q <= carry_nx;
					res_kind_q <= KIND_DONE;
					res_val_q <= '0;
				end
				CMD_PLOT: begin
					op_addr_q <= pos_addr;
					op_val_q <= pcolor;
					op_mask_q <= pmask;
					op_xor_q <= p.xor_mode;
					op_pix_q <= pix;
					res_kind_q <= KIND_PIXEL;
					res_val_q <= '0;
				end
				CMD_READ: begin
					res_kind_q <= KIND_READ;
					res_val_q <= '0;
				end
				default: res_val_q <= '0;
			endcase
		end
		if (state_q == ST_W1) begin
			wb_q <= new_byte;
			if (op_plot_q) res_val_q <= BYTE_W'(old_sh[BYTE_W-1:BYTE_W-COLOR_W]);
		end
		if (state_q == ST_SPILL) begin
			op_addr_q <= spill_addr_q;
			op_val_q <= spill_val_q;
		end
		if (state_q == ST_RDATA) res_val_q <= rd_data;
		if (state_q == ST_SEND && out_free) begin
			out_kind_q <= res_kind_q;
			out_coll_q <= (res_kind_q == KIND_DONE) && hit_q;
			out_val_q <= res_val_q;
		end
	end

`ifndef SYNTHESIS
	a_port_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(rd_en && wr_en))
		else $error("frame memory read and write in the same cycle");

	a_wr_range: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (int'(wr_addr) < STORE_SIZE))
		else $error("frame memory write outside the store");

	a_copy_follows: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_W1 |=> state_q == ST_W2)
		else $error("first-copy write not followed by second-copy write");

	a_rows_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rows_lim_q <= rows_left_q)
		else $error("drawn row limit exceeds rows left");

	a_rsp_from_send: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_SEND)
		else $error("result slot loaded outside the send step");
`endif

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking bench for xor_sprite_blitter_collision: directed and random blits, plots, reads.
// Depends on xsb_pkg, xsb_req_if, xsb_rsp_if and the blitter RTL.
module tb_top;
	import xsb_pkg::*;

	localparam int CLK_PERIOD = 4;
	localparam int SCREEN_ROWS = 200;
	localparam int LINE_BYTES = 80;
	localparam int PAIR_BYTES = 2 * LINE_BYTES;
	localparam int STORE_BYTES = SCREEN_ROWS * PAIR_BYTES;
	localparam int MAX_SPRITE_BYTES = 16;
	localparam int MAX_SPRITE_ROWS = 64;
	localparam int RANDOM_ITEMS = 1500;
	localparam int LONG_HOLD = 500;
	localparam int CYCLE_LIMIT = 400000;

	class blit_scoreboard;
		logic [7:0] frame [STORE_BYTES];
		logic [14:0] row_base;
		logic [4:0] byte_in_row;
		logic [6:0] rows_left;
		logic [7:0] rows_drawn_limit;
		logic [4:0] clipped_width;
		logic [4:0] sprite_width;
		logic [2:0] shift_amount;
		logic [7:0] carry_bits;
		logic hit_flag;
		logic blit_active;
		logic spill_on;
		rsp_t expected_q[$];
		int err_count;

		function new();
			foreach (frame[i])
				frame[i] = 8'h00;
			row_base = '0;
			byte_in_row = '0;
			rows_left = '0;
			rows_drawn_limit = '0;
			clipped_width = '0;
			sprite_width = '0;
			shift_amount = '0;
			carry_bits = '0;
			hit_flag = 1'b0;
			blit_active = 1'b0;
			spill_on = 1'b0;
			err_count = 0;
		endfunction

		function logic [7:0] pixel_mask(logic [7:0] v);
			logic [7:0] m;
			for (int p = 0; p < 8; p += 2)
				m[p +: 2] = (v[p +: 2] != 2'b00) ? 2'b11 : 2'b00;
			return m;
		endfunction

		function void xor_into_rows(int unsigned addr, logic [7:0] v);
			if (addr + LINE_BYTES < STORE_BYTES) begin
				if ((frame[addr] & pixel_mask(v)) != 8'h00)
					hit_flag = 1'b1;
				frame[addr] ^= v;
				frame[addr + LINE_BYTES] ^= v;
			end
		endfunction

		function void note_cmd(req_t r);
			rsp_t e;
			int unsigned col, w, h, avail, addr;
			logic [2:0] sh;
			logic [7:0] mask, c;
			logic draw;
			e = '0;
			col = r.x_pos >> 2;
			case (r.cmd)
				CMD_START: begin
					w = (r.width_bytes > MAX_SPRITE_BYTES) ? MAX_SPRITE_BYTES : r.width_bytes;
					h = (r.height_rows > MAX_SPRITE_ROWS) ? MAX_SPRITE_ROWS : r.height_rows;
					hit_flag = 1'b0;
					if (w == 0 || h == 0) begin
						blit_active = 1'b0;
						e.result_kind = KIND_DONE;
						expected_q.push_back(e);
					end else begin
						avail = (col < LINE_BYTES) ? LINE_BYTES - col : 0;
						sprite_width = w;
						clipped_width = (w < avail) ? w : avail;
						spill_on = (w < avail);
						shift_amount = {r.x_pos[1:0], 1'b0};
						if (r.y_pos >= SCREEN_ROWS) begin
							rows_drawn_limit = 0;
							row_base = 0;
						end else begin
							rows_drawn_limit = (h < r.y_pos + 1) ? h : r.y_pos + 1;
							row_base = (SCREEN_ROWS - 1 - r.y_pos) * PAIR_BYTES + col;
						end
						byte_in_row = 0;
						rows_left = h;
						carry_bits = 8'h00;
						blit_active = 1'b1;
					end
				end
				CMD_DATA: begin
					if (blit_active) begin
						draw = (rows_drawn_limit > 0);
						if (draw && byte_in_row < clipped_width)
							xor_into_rows(row_base + byte_in_row,
								(r.data_byte >> shift_amount) | carry_bits);
						carry_bits = (shift_amount != 0) ?
							r.data_byte << (8 - shift_amount) : 8'h00;
						byte_in_row++;
						if (byte_in_row >= sprite_width) begin
							if (draw && spill_on)
								xor_into_rows(row_base + sprite_width, carry_bits);
							carry_bits = 8'h00;
							byte_in_row = 0;
							row_base += PAIR_BYTES;
							if (rows_drawn_limit > 0)
								rows_drawn_limit--;
							if (rows_left > 0)
								rows_left--;
							if (rows_left == 0) begin
								blit_active = 1'b0;
								e.result_kind = KIND_DONE;
								e.collided = hit_flag;
								expected_q.push_back(e);
							end
						end
					end
				end
				CMD_PLOT: begin
					e.result_kind = KIND_PIXEL;
					if (col < LINE_BYTES && r.y_pos < SCREEN_ROWS) begin
						addr = (SCREEN_ROWS - 1 - r.y_pos) * PAIR_BYTES + col;
						sh = {r.x_pos[1:0], 1'b0};
						mask = 8'hC0 >> sh;
						c = ({6'b0, r.pixel_color} << (6 - sh)) & mask;
						if (addr + LINE_BYTES < STORE_BYTES) begin
							e.out_value = (frame[addr] & mask) >> (6 - sh);
							if (r.xor_mode) begin
								frame[addr] ^= c;
								frame[addr + LINE_BYTES] ^= c;
							end else begin
								frame[addr] = (frame[addr] & ~mask) | c;
								frame[addr + LINE_BYTES] = (frame[addr + LINE_BYTES] & ~mask) | c;
							end
						end
					end
					expected_q.push_back(e);
				end
				default: begin
					e.result_kind = KIND_READ;
					if (r.read_address < STORE_BYTES)
						e.out_value = frame[r.read_address];
					expected_q.push_back(e);
				end
			endcase
		endfunction

		function void check_rsp(rsp_t got);
			rsp_t e;
			if (expected_q.size() == 0) begin
				$error("result with none pending: kind %0d collided %0d value %0d",
					got.result_kind, got.collided, got.out_value);
				err_count++;
			end else begin
				e = expected_q.pop_front();
				if (got.result_kind !== e.result_kind) begin
					$error("result_kind: expected %0d, actual %0d", e.result_kind, got.result_kind);
					err_count++;
				end
				if (got.collided !== e.collided) begin
					$error("collided: expected %0d, actual %0d", e.collided, got.collided);
					err_count++;
				end
				if (got.out_value !== e.out_value) begin
					$error("out_value: expected %0d, actual %0d", e.out_value, got.out_value);
					err_count++;
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit steady;
	bit hold_rsp;
	int counted_items;
	int cycle_count;
	blit_scoreboard sb = new();

	xsb_req_if req ();
	xsb_rsp_if rsp ();

	xor_sprite_blitter_collision dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	initial clk = 1'b0;
	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic req_t noise_req(logic [CMD_W-1:0] cmd);
		req_t r;
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		r = raw[$bits(req_t)-1:0];
		r.cmd = cmd;
		return r;
	endfunction

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic int pick_x();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: return $urandom_range(0, 60);
			5, 6: return $urandom_range(280, 319);
			7: return $urandom_range(320, 511);
			default: return $urandom_range(0, 319);
		endcase
	endfunction

	function automatic int pick_y();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return $urandom_range(170, 199);
			4, 5: return $urandom_range(0, 8);
			6: return $urandom_range(200, 255);
			default: return $urandom_range(0, 199);
		endcase
	endfunction

	function automatic int sprite_bytes(int w, int h);
		int wc, hc;
		wc = (w > MAX_SPRITE_BYTES) ? MAX_SPRITE_BYTES : w;
		hc = (h > MAX_SPRITE_ROWS) ? MAX_SPRITE_ROWS : h;
		return wc * hc;
	endfunction

	task automatic send_req(input req_t r);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 8);
		@(negedge clk);
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req.payload <= r;
		req.valid <= 1'b1;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		if (r.cmd != CMD_DATA || sb.blit_active)
			counted_items++;
		sb.note_cmd(r);
	endtask

	task automatic wait_results_drained();
		@(negedge clk);
		req.valid <= 1'b0;
		while (sb.expected_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic start_blit(int x, int y, int w, int h);
		req_t r;
		r = noise_req(CMD_START);
		r.x_pos = x;
		r.y_pos = y;
		r.width_bytes = w;
		r.height_rows = h;
		send_req(r);
	endtask

	task automatic send_byte(logic [7:0] b);
		req_t r;
		r = noise_req(CMD_DATA);
		r.data_byte = b;
		send_req(r);
	endtask

	task automatic plot_pixel(int x, int y, int color, bit xr);
		req_t r;
		r = noise_req(CMD_PLOT);
		r.x_pos = x;
		r.y_pos = y;
		r.pixel_color = color;
		r.xor_mode = xr;
		send_req(r);
	endtask

	task automatic read_byte(int addr);
		req_t r;
		r = noise_req(CMD_READ);
		r.read_address = addr;
		send_req(r);
	endtask

	task automatic side_access();
		if ($urandom_range(0, 1))
			plot_pixel(pick_x(), pick_y(), $urandom_range(0, 3), $urandom_range(0, 1));
		else
			read_byte((199 - $urandom_range(170, 199)) * PAIR_BYTES + $urandom_range(0, 20));
	endtask

	// cut below zero sends the whole sprite
	task automatic run_blit(int x, int y, int w, int h, int cut, bit interleave);
		int total;
		start_blit(x, y, w, h);
		total = sprite_bytes(w, h);
		if (cut >= 0 && cut < total)
			total = cut;
		for (int i = 0; i < total; i++) begin
			if (interleave && $urandom_range(0, 19) == 0)
				side_access();
			send_byte(pick_byte());
		end
	endtask

	task automatic read_near(int x, int y);
		int addr;
		repeat (2) begin
			addr = (199 - y) * PAIR_BYTES + x / 4 + $urandom_range(0, 6)
				+ PAIR_BYTES * $urandom_range(0, 3) + ($urandom_range(0, 1) ? LINE_BYTES : 0);
			read_byte(addr);
		end
	endtask

	task automatic pick_size(output int w, output int h);
		case ($urandom_range(0, 19))
			0: begin
				w = $urandom_range(17, 31);
				h = $urandom_range(1, 2);
			end
			1: begin
				w = $urandom_range(0, 1);
				h = $urandom_range(65, 127);
			end
			2: begin
				w = $urandom_range(0, 1) ? 0 : $urandom_range(1, 31);
				h = (w == 0) ? $urandom_range(0, 127) : 0;
			end
			default: begin
				w = $urandom_range(1, 4);
				h = $urandom_range(1, 5);
			end
		endcase
	endtask

	initial begin
		int stall;
		rsp.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = steady ? 0 : $urandom_range(0, 8);
			if (hold_rsp) begin
				stall = LONG_HOLD;
				hold_rsp = 1'b0;
			end
			@(negedge clk);
			if (stall > 0) begin
				rsp.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			rsp.ready <= 1'b1;
			@(posedge clk);
			while (!rsp.valid)
				@(posedge clk);
			sb.check_rsp(rsp.payload);
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("xor_sprite_blitter_collision test failed");
		$finish;
	end

	initial begin
		int x, y, w, h, pick, total;
		bit mid_done;
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.payload = '0;
		steady = 1'b0;
		hold_rsp = 1'b0;
		counted_items = 0;
		mid_done = 1'b0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		read_byte(0);
		read_byte(STORE_BYTES - 1);
		read_byte(32767);
		plot_pixel(0, 199, 3, 1'b0);
		plot_pixel(0, 199, 1, 1'b1);
		read_byte(0);
		plot_pixel(319, 0, 2, 1'b0);
		plot_pixel(320, 10, 3, 1'b0);
		plot_pixel(511, 255, 3, 1'b1);
		plot_pixel(5, 200, 1, 1'b0);
		start_blit(0, 50, 0, 5);
		start_blit(0, 50, 3, 0);
		send_byte(8'hA5);
		start_blit(1, 199, 1, 1);
		send_byte(8'hFF);
		start_blit(1, 199, 1, 1);
		send_byte(8'hFF);
		start_blit(100, 120, 31, 127);
		send_byte(8'h5A);
		start_blit(317, 0, 2, 2);
		send_byte(8'hFF);
		send_byte(8'h81);
		send_byte(8'h3C);
		send_byte(8'hC3);
		start_blit(8, 200, 1, 1);
		send_byte(8'hFF);
		read_byte(1);
		read_byte(LINE_BYTES);

		wait_results_drained();
		counted_items = 0;
		hold_rsp = 1'b1;
		while (counted_items < RANDOM_ITEMS) begin
			if ($urandom_range(0, 7) == 0)
				steady = ~steady;
			if (!mid_done && counted_items >= RANDOM_ITEMS / 2) begin
				wait_results_drained();
				hold_rsp = 1'b1;
				mid_done = 1'b1;
			end
			pick = $urandom_range(0, 99);
			x = pick_x();
			y = pick_y();
			if (pick < 65) begin
				pick_size(w, h);
				run_blit(x, y, w, h, -1, 1'b1);
				if (y < SCREEN_ROWS && x < 4 * LINE_BYTES && $urandom_range(0, 1))
					read_near(x, y);
			end else if (pick < 80) begin
				plot_pixel(x, y, $urandom_range(0, 3), $urandom_range(0, 1));
			end else if (pick < 92) begin
				if ($urandom_range(0, 1))
					read_byte($urandom_range(0, 32767));
				else
					read_byte((199 - $urandom_range(170, 199)) * PAIR_BYTES
						+ $urandom_range(0, 20));
			end else if (pick < 97) begin
				pick_size(w, h);
				total = sprite_bytes(w, h);
				run_blit(x, y, w, h, (total > 0) ? $urandom_range(0, total - 1) : 0, 1'b0);
			end else begin
				send_byte(pick_byte());
			end
		end

		wait_results_drained();
		repeat (40) @(posedge clk);
		if (sb.err_count == 0)
			$display("xor_sprite_blitter_collision test passed");
		else
			$display("xor_sprite_blitter_collision test failed");
		$finish;
	end

endmodule
